// ===== design/clsu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsu_pkg: shared types for the C string literal unescaper
// Decoder state, result items and the decoder output bundle.
// ----------------------------------------------------------------------------
package clsu_pkg;

  // Position inside a literal.
  typedef enum logic [2:0] {
    M_IDLE,
    M_TEXT,
    M_ESC,
    M_HEX0,
    M_HEX1
  } mode_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] held_digit;
    logic       ok_flag;
    logic       suppress;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       is_status;
    logic       ok;
    logic       run_end;
  } result_t;

  // Everything the decoder produces for one request.
  typedef struct packed {
    dec_state_t state_next;
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } dec_out_t;

  localparam dec_state_t STATE_RESET = '{
    mode:       M_IDLE,
    held_digit: 8'h00,
    ok_flag:    1'b1,
    suppress:   1'b0
  };

  localparam int OUTQ_DEPTH = 3;
  localparam int OUTQ_CW    = 2;

endpackage

// ===== design/clsu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsu_decode: combinational escape decoder
// Computes the next decoder state and up to two results for one character.
// ----------------------------------------------------------------------------
module clsu_decode import clsu_pkg::*; (
  input  dec_state_t cur,
  input  logic [7:0] char_in,
  input  logic       is_first,
  input  logic       is_last,
  output dec_out_t   dout
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  typedef struct packed {
    mode_t      mode;
    logic       emit;
    logic [7:0] b;
    logic       err;
  } text_res_t;

  // Bit 4 set when the character is a hex digit.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  // Bit 8 set when the character names a simple escape.
  function automatic logic [8:0] simple_escape(input logic [7:0] c);
    logic [8:0] r;
    case (c)
      8'h61, 8'h41: r = {1'b1, 8'd7};
      8'h62, 8'h42: r = {1'b1, 8'd8};
      8'h66, 8'h46: r = {1'b1, 8'd12};
      8'h6E, 8'h4E: r = {1'b1, 8'd10};
      8'h72, 8'h52: r = {1'b1, 8'd13};
      8'h74, 8'h54: r = {1'b1, 8'd9};
      8'h76, 8'h56: r = {1'b1, 8'd11};
      8'h27:        r = {1'b1, 8'h27};
      8'h22:        r = {1'b1, 8'h22};
      8'h5C:        r = {1'b1, 8'h5C};
      8'h3F:        r = {1'b1, 8'h3F};
      8'h30:        r = {1'b1, 8'h00};
      default:      r = 9'd0;
    endcase
    return r;
  endfunction

  // One character seen as text; any mode other than after-backslash is text.
  function automatic text_res_t text_step(input mode_t m, input logic [7:0] c);
    text_res_t  r;
    logic [8:0] e;
    e = simple_escape(c);
    r = '{mode: m, emit: 1'b0, b: c, err: 1'b0};
    if (m == M_ESC) begin
      if (c == CH_X) begin
        r.mode = M_HEX0;
      end else begin
        r.mode = M_TEXT;
        r.emit = e[8];
        r.b    = e[7:0];
        r.err  = !e[8];
      end
    end else if (c == CH_BSLASH) begin
      r.mode = M_ESC;
    end else begin
      r.emit = 1'b1;
    end
    return r;
  endfunction

  logic [4:0] hv_hi;
  logic [4:0] hv_lo;
  text_res_t  t0;
  text_res_t  t1;
  logic       e0;
  logic       e1;
  logic [7:0] b0;
  logic [7:0] b1;
  logic       status;
  logic       okv;

  assign hv_hi = hex_val(cur.held_digit);
  assign hv_lo = hex_val(char_in);

  always_comb begin
    dout.state_next = cur;
    e0     = 1'b0;
    e1     = 1'b0;
    b0     = 8'd0;
    b1     = 8'd0;
    status = 1'b0;
    okv    = cur.ok_flag;
    t0     = text_step(cur.mode, cur.held_digit);
    t1     = text_step(t0.mode, char_in);

    if (is_first) begin
      dout.state_next = STATE_RESET;
      if (is_last) begin
        status = 1'b1;
        okv    = 1'b0;
      end else begin
        dout.state_next.mode = M_TEXT;
        if (char_in != CH_QUOTE) begin
          dout.state_next.ok_flag  = 1'b0;
          dout.state_next.suppress = 1'b1;
        end
      end
    end else if (cur.mode == M_IDLE) begin
      dout.state_next = cur;
    end else if (!is_last) begin
      case (cur.mode)
        M_HEX0: begin
          dout.state_next.held_digit = char_in;
          dout.state_next.mode       = M_HEX1;
        end
        M_HEX1: begin
          if (hv_hi[4] && hv_lo[4]) begin
            dout.state_next.mode = M_TEXT;
            e0 = 1'b1;
            b0 = {hv_hi[3:0], hv_lo[3:0]};
          end else begin
            // Bad hex: replay both characters as text from text mode.
            t0 = text_step(M_TEXT, cur.held_digit);
            t1 = text_step(t0.mode, char_in);
            dout.state_next.ok_flag = 1'b0;
            dout.state_next.mode    = t1.mode;
            e0 = t0.emit;
            b0 = t0.b;
            e1 = t1.emit;
            b1 = t1.b;
          end
        end
        default: begin
          t0 = text_step(cur.mode, char_in);
          dout.state_next.mode = t0.mode;
          if (t0.err) dout.state_next.ok_flag = 1'b0;
          e0 = t0.emit;
          b0 = t0.b;
        end
      endcase
    end else begin
      status = 1'b1;
      case (cur.mode)
        M_ESC: begin
          e0 = 1'b1;
          b0 = CH_BSLASH;
        end
        M_HEX0: okv = 1'b0;
        M_HEX1: begin
          okv = 1'b0;
          e0  = 1'b1;
          b0  = cur.held_digit;
        end
        default: ;
      endcase
      if (char_in != CH_QUOTE) okv = 1'b0;
      dout.state_next = STATE_RESET;
    end

    e0 = e0 && !cur.suppress;
    e1 = e1 && !cur.suppress;

    // Pack byte results first, then the status result, without gaps.
    dout.res0  = '0;
    dout.res1  = '0;
    dout.count = 2'd0;
    if (e0) begin
      dout.res0 = '{byte_out: b0, is_status: 1'b0, ok: 1'b0, run_end: !(e1 || status)};
      if (e1) dout.res1 = '{byte_out: b1, is_status: 1'b0, ok: 1'b0, run_end: 1'b1};
      else if (status) dout.res1 = '{byte_out: 8'd0, is_status: 1'b1, ok: okv, run_end: 1'b1};
      dout.count = (e1 || status) ? 2'd2 : 2'd1;
    end else if (e1) begin
      dout.res0 = '{byte_out: b1, is_status: 1'b0, ok: 1'b0, run_end: 1'b1};
      dout.count = 2'd1;
    end else if (status) begin
      dout.res0 = '{byte_out: 8'd0, is_status: 1'b1, ok: okv, run_end: 1'b1};
      dout.count = 2'd1;
    end
  end

endmodule

// ===== design/clsu_outq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsu_outq: result queue
// Three-entry shifting queue that takes up to two results per cycle.
// ----------------------------------------------------------------------------
module clsu_outq import clsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  result_t    push0,
  input  result_t    push1,
  output logic       space,
  output logic       out_valid,
  input  logic       out_ready,
  output result_t    out_res
);

  result_t            q [OUTQ_DEPTH];
  result_t            q_next [OUTQ_DEPTH];
  logic [OUTQ_CW-1:0] count;
  logic [OUTQ_CW-1:0] count_next;
  logic [OUTQ_CW-1:0] cnt_pop;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_res   = q[0];
  // Room for two results regardless of whether the head leaves this cycle.
  assign space     = (count <= OUTQ_CW'(1));

  always_comb begin
    cnt_pop = count - OUTQ_CW'(pop);
    for (int i = 0; i < OUTQ_DEPTH - 1; i++) begin
      q_next[i] = pop ? q[i + 1] : q[i];
    end
    q_next[OUTQ_DEPTH-1] = q[OUTQ_DEPTH-1];
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      if (push_count != 2'd0 && OUTQ_CW'(i) == cnt_pop) q_next[i] = push0;
      if (push_count == 2'd2 && OUTQ_CW'(i) == OUTQ_CW'(cnt_pop + 1'b1)) q_next[i] = push1;
    end
    count_next = cnt_pop + OUTQ_CW'(push_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUTQ_DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

endmodule

// ===== design/c_string_literal_unescaper_unit.sv =====
`timescale 1ns / 1ps
// Flow: an accepted request is held in the input register, decoded once the
// queue has room for two results, then written to the queue and offered.
// Throughput: one character per cycle while the queue has room for two
// results; a character that yields two results (bad hex replay, or a trailing
// byte before the status) leaves too little room, so the next one waits.
// Reset: synchronous, active high; empties both registers and the queue.
// ----------------------------------------------------------------------------
// c_string_literal_unescaper_unit: streaming C string literal decoder
// Drops the quotes, decodes escapes and reports an end-of-literal status.
// ----------------------------------------------------------------------------
module c_string_literal_unescaper_unit import clsu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] is_first
  input  logic        s_axis_tlast,   // is_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [8] ok, [15:9] zero
  output logic        m_axis_tuser,   // [0] is_status
  output logic        m_axis_tlast    // run_end
);

  // Input register: holds one request until the decoder takes it.
  logic       in_valid;
  logic [7:0] in_char;
  logic       in_first;
  logic       in_last;

  // Decoder state, updated only when a request is decoded.
  dec_state_t dstate;
  dec_out_t   dout;

  logic       space;
  logic       fire;
  logic       load;
  result_t    out_res;

  // A request is decoded when the queue has room for two results. The queue
  // room flag comes from its registered count, so the input side never waits
  // on the output ready in the same cycle.
  assign fire          = in_valid && space;
  assign s_axis_tready = !in_valid || space;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (load) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_char  <= s_axis_tdata;
      in_first <= s_axis_tuser;
      in_last  <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= STATE_RESET;
    end else if (fire) begin
      dstate <= dout.state_next;
    end
  end

  clsu_decode u_decode (
    .cur      (dstate),
    .char_in  (in_char),
    .is_first (in_first),
    .is_last  (in_last),
    .dout     (dout)
  );

  clsu_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (fire ? dout.count : 2'd0),
    .push0      (dout.res0),
    .push1      (dout.res1),
    .space      (space),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_res    (out_res)
  );

  assign m_axis_tdata = {7'd0, out_res.ok, out_res.byte_out};
  assign m_axis_tuser = out_res.is_status;
  assign m_axis_tlast = out_res.run_end;

endmodule

// ===== design/clsu_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clsu_checker: port-level checks for the unescaper
// Watches the output stream for protocol and result-format slips.
// ----------------------------------------------------------------------------
module clsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output result withdrawn while stalled");

  // A status result carries no byte and always ends its run.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[7:0] == 8'd0 && m_axis_tlast)
    else $error("malformed status result");

  // A byte result never carries the ok flag or padding bits.
  a_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:8] == 8'd0)
    else $error("byte result with nonzero upper bits");

  // Reset empties the output queue.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind c_string_literal_unescaper_unit clsu_checker u_clsu_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the C string literal unescaper
// Streams quoted literals into the unit, including escapes, broken hex
// escapes, bad quotes and stray characters, under random stalls on both
// sides. A behavioral decoder inside the bench predicts every result.
// ----------------------------------------------------------------------------
module tb;
  import clsu_pkg::*;

  // Characters that steer the decoder.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam int RANDOM_ITEMS = 1550;
  localparam int PHASE_LEN    = 100;   // requests sent per idling phase
  localparam int STALL_LIMIT  = 2000;  // cycles without any handshake
  localparam int DRAIN_CYCLES = 10;

  // Idling phases, selected by the number of requests sent so far.
  typedef enum int {
    PH_STEADY,
    PH_SLOW_SOURCE,
    PH_SLOW_SINK,
    PH_BOTH
  } phase_t;

  // One character request as it travels on the slave side.
  typedef struct packed {
    logic [7:0] ch;
    logic       first;
    logic       last;
  } char_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] char_in
  logic        s_axis_tuser = 1'b0;     // [0] is_first
  logic        s_axis_tlast = 1'b0;     // is_last
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;            // [7:0] byte_out, [8] ok, [15:9] zero
  logic        m_axis_tuser;            // [0] is_status
  logic        m_axis_tlast;            // run_end

  c_string_literal_unescaper_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  char_req_t char_q[$];      // requests still to be sent
  result_t   decoded_q[$];   // decoded bytes and statuses still to arrive
  result_t   step_out[$];    // results of the request being decoded
  bit        failed = 1'b0;
  int        sent_cnt = 0;
  phase_t    phase = PH_STEADY;
  int        stall_cnt = 0;

  // Shadow copy of the decoder state.
  mode_t      lit_mode = M_IDLE;
  logic [7:0] lit_held = 8'h00;
  logic       lit_ok = 1'b1;
  logic       lit_mute = 1'b0;

  // --------------------------------------------------------------------------
  // Decoder model
  // --------------------------------------------------------------------------

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Byte that a simple escape letter stands for, or -1 when it is not one.
  function automatic int escape_code(input logic [7:0] c);
    case (c)
      "a", "A": return 7;
      "b", "B": return 8;
      "f", "F": return 12;
      "n", "N": return 10;
      "r", "R": return 13;
      "t", "T": return 9;
      "v", "V": return 11;
      CH_QUOTE, 8'h27, CH_BSLASH, "?": return int'(c);
      "0": return 0;
      default: return -1;
    endcase
  endfunction

  task automatic lit_clear();
    lit_mode = M_IDLE;
    lit_held = 8'h00;
    lit_ok   = 1'b1;
    lit_mute = 1'b0;
  endtask

  // A literal with a bad opening quote produces no bytes at all.
  task automatic put_byte(input logic [7:0] b);
    result_t item;
    item = '{byte_out: b, is_status: 1'b0, ok: 1'b0, run_end: 1'b0};
    if (!lit_mute && step_out.size() < 2)
      step_out.insert(step_out.size(), item);
  endtask

  task automatic text_char(input logic [7:0] c);
    int e;
    if (lit_mode == M_ESC) begin
      if (c == CH_X) begin
        lit_mode = M_HEX0;
      end else begin
        e = escape_code(c);
        // An unknown escape drops both the backslash and the letter.
        if (e < 0) lit_ok = 1'b0;
        else put_byte(e[7:0]);
        lit_mode = M_TEXT;
      end
    end else if (c == CH_BSLASH) begin
      lit_mode = M_ESC;
    end else begin
      put_byte(c);
    end
  endtask

  task automatic content_char(input logic [7:0] c);
    int hi;
    int lo;
    if (lit_mode == M_HEX0) begin
      lit_held = c;
      lit_mode = M_HEX1;
    end else if (lit_mode == M_HEX1) begin
      hi = hex_value(lit_held);
      lo = hex_value(c);
      lit_mode = M_TEXT;
      if (hi >= 0 && lo >= 0) begin
        put_byte(8'((hi << 4) | lo));
      end else begin
        // Broken hex: the x is lost and both characters are read again as
        // text, so they may open a new escape or give two bytes at once.
        lit_ok = 1'b0;
        text_char(lit_held);
        text_char(c);
      end
    end else begin
      text_char(c);
    end
  endtask

  // Works out the results of one accepted request and queues them.
  task automatic decode_request(input char_req_t r);
    result_t tail;
    result_t st;
    bit      closing;
    step_out.delete();
    closing = 1'b0;
    if (r.first) begin
      // A new opening character abandons any open literal silently.
      lit_clear();
      if (r.last) begin
        lit_ok  = 1'b0;
        closing = 1'b1;
      end else begin
        lit_mode = M_TEXT;
        if (r.ch != CH_QUOTE) begin
          lit_ok   = 1'b0;
          lit_mute = 1'b1;
        end
      end
    end else if (lit_mode != M_IDLE) begin
      if (!r.last) begin
        content_char(r.ch);
      end else begin
        // Unfinished escapes at the closing character.
        if (lit_mode == M_ESC) begin
          put_byte(CH_BSLASH);
        end else if (lit_mode == M_HEX0) begin
          lit_ok = 1'b0;
        end else if (lit_mode == M_HEX1) begin
          lit_ok = 1'b0;
          put_byte(lit_held);
        end
        if (r.ch != CH_QUOTE) lit_ok = 1'b0;
        closing = 1'b1;
      end
    end
    if (closing) begin
      st = '{byte_out: 8'h00, is_status: 1'b1, ok: lit_ok, run_end: 1'b0};
      step_out.insert(step_out.size(), st);
      lit_clear();
    end
    if (step_out.size() != 0) begin
      tail = step_out.pop_back();
      tail.run_end = 1'b1;
      step_out.insert(step_out.size(), tail);
    end
    while (step_out.size() != 0) decoded_q.insert(decoded_q.size(), step_out.pop_front());
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------

  task automatic add_req(input logic [7:0] ch, input logic first, input logic last);
    char_req_t r;
    r = '{ch: ch, first: first, last: last};
    char_q.insert(char_q.size(), r);
  endtask

  function automatic logic [7:0] hex_char(input int v, input bit upper);
    if (v < 10) return 8'("0" + v);
    return upper ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] any_but_quote();
    logic [7:0] c;
    c = 8'($urandom_range(255));
    if (c == CH_QUOTE) c = c ^ 8'h01;
    return c;
  endfunction

  // One piece of literal content: a plain character or some kind of escape.
  task automatic add_token();
    int         kind;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (kind < 50) begin
      c = 8'($urandom_range(255));
      if (c == CH_BSLASH) c = c ^ 8'h80;
      add_req(c, 1'b0, 1'b0);
    end else if (kind < 70) begin
      do c = 8'($urandom_range(255)); while (escape_code(c) < 0);
      add_req(CH_BSLASH, 1'b0, 1'b0);
      add_req(c, 1'b0, 1'b0);
    end else if (kind < 85) begin
      add_req(CH_BSLASH, 1'b0, 1'b0);
      add_req(CH_X, 1'b0, 1'b0);
      add_req(hex_char(int'($urandom_range(15)), 1'($urandom_range(1))), 1'b0, 1'b0);
      add_req(hex_char(int'($urandom_range(15)), 1'($urandom_range(1))), 1'b0, 1'b0);
    end else if (kind < 93) begin
      do c = 8'($urandom_range(255)); while (escape_code(c) >= 0 || c == CH_X);
      add_req(CH_BSLASH, 1'b0, 1'b0);
      add_req(c, 1'b0, 1'b0);
    end else begin
      // Mostly broken hex; half the time one digit comes from a real escape.
      add_req(CH_BSLASH, 1'b0, 1'b0);
      add_req(CH_X, 1'b0, 1'b0);
      add_req($urandom_range(1) ? CH_BSLASH : 8'($urandom_range(255)), 1'b0, 1'b0);
      add_req(8'($urandom_range(255)), 1'b0, 1'b0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: sends one request per handshake, with random gaps per phase.
  // --------------------------------------------------------------------------

  function automatic int source_idle_pct(input phase_t p);
    case (p)
      PH_SLOW_SOURCE: return 71;
      PH_BOTH:        return 19;
      default:        return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct(input phase_t p);
    case (p)
      PH_SLOW_SINK: return 71;
      PH_BOTH:      return 19;
      default:      return 0;
    endcase
  endfunction

  always @(posedge clk) begin
    char_req_t r;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (char_q.size() != 0 && $urandom_range(99) >= source_idle_pct(phase)) begin
        r = char_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= r.ch;
        s_axis_tuser  <= r.first;
        s_axis_tlast  <= r.last;
        sent_cnt      <= sent_cnt + 1;
        phase         <= phase_t'(((sent_cnt + 1) / PHASE_LEN) % 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // The sink stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= sink_stall_pct(phase));
  end

  // --------------------------------------------------------------------------
  // Monitor: predicts on each accepted request, checks each accepted result.
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    result_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        decode_request('{ch: s_axis_tdata, first: s_axis_tuser, last: s_axis_tlast});
      if (m_axis_tvalid && m_axis_tready) begin
        if (decoded_q.size() == 0) begin
          $error("unexpected result: byte_out %h ok %b is_status %b run_end %b",
                 m_axis_tdata[7:0], m_axis_tdata[8], m_axis_tuser, m_axis_tlast);
          failed = 1'b1;
        end else begin
          want = decoded_q.pop_front();
          if (m_axis_tdata[7:0] !== want.byte_out) begin
            $error("byte_out: expected %h, got %h", want.byte_out, m_axis_tdata[7:0]);
            failed = 1'b1;
          end
          if (m_axis_tuser !== want.is_status) begin
            $error("is_status: expected %b, got %b", want.is_status, m_axis_tuser);
            failed = 1'b1;
          end
          if (m_axis_tdata[8] !== want.ok) begin
            $error("ok: expected %b, got %b", want.ok, m_axis_tdata[8]);
            failed = 1'b1;
          end
          if (m_axis_tlast !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, m_axis_tlast);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // Watchdog: a long stretch with no handshake on either side means a hang.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: directed literals, random literals, reset, drain, verdict.
  // --------------------------------------------------------------------------

  initial begin
    int         kind;
    int         n_tok;
    int         start_size;

    // A character outside any literal is ignored.
    add_req(8'hFF, 1'b0, 1'b0);
    // A literal of a single character: only a failing status.
    add_req(CH_QUOTE, 1'b1, 1'b1);
    // Zero escape, hex escape giving 0xFF, an unknown escape, broken hex that
    // replays two plain characters in one step, and a backslash right before
    // the closing quote.
    add_req(CH_QUOTE, 1'b1, 1'b0);
    add_req(CH_BSLASH, 1'b0, 1'b0);
    add_req("0", 1'b0, 1'b0);
    add_req(CH_BSLASH, 1'b0, 1'b0);
    add_req(CH_X, 1'b0, 1'b0);
    add_req("f", 1'b0, 1'b0);
    add_req("F", 1'b0, 1'b0);
    add_req(CH_BSLASH, 1'b0, 1'b0);
    add_req("q", 1'b0, 1'b0);
    add_req(CH_BSLASH, 1'b0, 1'b0);
    add_req(CH_X, 1'b0, 1'b0);
    add_req("G", 1'b0, 1'b0);
    add_req("1", 1'b0, 1'b0);
    add_req(CH_BSLASH, 1'b0, 1'b0);
    add_req(CH_QUOTE, 1'b0, 1'b1);
    // Bad opening quote: no bytes follow, the status fails.
    add_req(8'h00, 1'b1, 1'b0);
    add_req(8'hFF, 1'b0, 1'b0);
    add_req(CH_QUOTE, 1'b0, 1'b1);
    // Closing quote right after the x of a hex escape.
    add_req(CH_QUOTE, 1'b1, 1'b0);
    add_req(CH_BSLASH, 1'b0, 1'b0);
    add_req(CH_X, 1'b0, 1'b0);
    add_req(CH_QUOTE, 1'b0, 1'b1);

    // Random literals: mostly well formed with random content, the rest
    // stray characters, one-character literals, bad quotes, unfinished
    // escapes at the close, and literals abandoned by a new opening.
    start_size = char_q.size();
    while (char_q.size() < start_size + RANDOM_ITEMS) begin
      kind = $urandom_range(99);
      if (kind < 3) begin
        add_req(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
      end else if (kind < 6) begin
        add_req(8'($urandom_range(255)), 1'b1, 1'b1);
      end else begin
        add_req(kind < 11 ? any_but_quote() : CH_QUOTE, 1'b1, 1'b0);
        n_tok = ($urandom_range(9) == 0) ? $urandom_range(30) : $urandom_range(8);
        repeat (n_tok) add_token();
        kind = $urandom_range(99);
        if (kind < 6) begin
          add_req(CH_BSLASH, 1'b0, 1'b0);
        end else if (kind < 10) begin
          add_req(CH_BSLASH, 1'b0, 1'b0);
          add_req(CH_X, 1'b0, 1'b0);
        end else if (kind < 14) begin
          add_req(CH_BSLASH, 1'b0, 1'b0);
          add_req(CH_X, 1'b0, 1'b0);
          add_req(8'($urandom_range(255)), 1'b0, 1'b0);
        end
        kind = $urandom_range(99);
        // Under 6: no close, so the next opening abandons this literal.
        if (kind >= 6 && kind < 12) add_req(any_but_quote(), 1'b0, 1'b1);
        else if (kind >= 12) add_req(CH_QUOTE, 1'b0, 1'b1);
      end
    end

    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Wait until every request is taken and every result has come back.
    while (char_q.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== c_string_literal_unescaper_unit.f =====
design/clsu_pkg.sv
design/clsu_decode.sv
design/clsu_outq.sv
design/c_string_literal_unescaper_unit.sv
design/clsu_checker.sv
tb/tb.sv
